// ===== rtl/tds_pkg.sv =====
// shared types and constants for the timer divisor search block
// no dependencies

package tds_pkg;

  localparam int SRC_W      = 30;
  localparam int RATE_W     = 30;
  localparam int PRE_W      = 17;
  localparam int PRESC_W    = 16;
  localparam int RELOAD_W   = 16;
  localparam int ACH_W      = 30;
  localparam int STATUS_W   = 2;
  localparam int PROD_W     = RATE_W + PRE_W;
  localparam int CNT_W      = $clog2(SRC_W);
  localparam int PRE_LIMIT  = 65536;

  localparam int MAX_DIVISOR_DEF = 65536;
  localparam logic [SRC_W-1:0] SRC_RESET = 30'd100000000;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_IDX_SRC_CLOCK = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_ZERO  = 2'd1,
    STAT_ABOVE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_DIV1,
    S_PRE,
    S_MUL2,
    S_DIV2,
    S_DVS,
    S_MUL3,
    S_DIV3,
    S_DONE
  } state_t;

endpackage

// ===== rtl/timer_divisor_search.sv =====
// timer divisor search top level: sequencer, shared multiplier and restoring divider
// depends on tds_pkg
//
// usage:
//   input channel in_valid/in_ready carries one requested rollover rate per transaction.
//   output channel out_valid/out_ready returns prescaler, reload value, achieved rate
//   and status for each transaction, in order.
//   the apb port (psel, penable, pwrite, paddr, pwdata, prdata, pready) holds the
//   source clock register at byte address 0; pready is always high.
// sequencing:
//   a normal request runs from acceptance to out_valid through three passes
//   through one 30-step restoring divider, each preceded by a multiply on the shared
//   multiplier, plus two clamp states (S_PRE, S_DVS) and a result load in S_DONE.
//   a zero rate or a rate above the source clock goes straight to the result load.
//   one transaction is in work at a time, and a new one is taken only once the last
//   result is loaded; in_ready is high only when the sequencer is idle, which it may
//   be while a finished result still waits at the output.
// reset:
//   synchronous active-low rst_n empties the output and sets the source clock to
//   100000000 hz.
// stall:
//   a stalled receiver holds the result in the output register; a finished
//   computation waits in its last state until the output register is free.

module timer_divisor_search
  import tds_pkg::*;
#(
  parameter int MAX_DIVISOR = MAX_DIVISOR_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,

  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [RATE_W-1:0]       in_requested_rate_hz,

  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [PRESC_W-1:0]      out_prescaler,
  output logic [RELOAD_W-1:0]     out_reload_value,
  output logic [ACH_W-1:0]        out_achieved_rate_hz,
  output logic [STATUS_W-1:0]     out_status,

  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CFG_ADDR_W-1:0]   paddr,
  input  logic [CFG_DATA_W-1:0]   pwdata,
  output logic [CFG_DATA_W-1:0]   prdata,
  output logic                    pready
);

  localparam int DIV_W = $clog2(MAX_DIVISOR + 1);
  localparam logic [PRE_W-1:0] DIV_LIMIT_P1 = PRE_W'(MAX_DIVISOR + 1);

  state_t               state_r, state_nxt;
  status_t              status_r, status_nxt;
  logic [SRC_W-1:0]     src_r;
  logic [RATE_W-1:0]    rate_r, rate_nxt;
  logic [PROD_W-1:0]    prod_r, prod_nxt;
  logic [SRC_W-1:0]     rem_r, rem_nxt;
  logic [SRC_W-1:0]     quo_r, quo_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [PRE_W-1:0]     pre_r, pre_nxt;
  logic [DIV_W-1:0]     div_r, div_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [PRESC_W-1:0]   out_prescaler_r, out_prescaler_nxt;
  logic [RELOAD_W-1:0]  out_reload_r, out_reload_nxt;
  logic [ACH_W-1:0]     out_ach_r, out_ach_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;

  logic [RATE_W-1:0]    mul_a;
  logic [PRE_W-1:0]     mul_b;
  logic [PROD_W-1:0]    mul_p;
  logic [SRC_W:0]       rem_sh;
  logic [PROD_W:0]      diff;
  logic                 ge;
  logic                 div_last;
  logic                 out_free;
  logic                 cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_IDX_SRC_CLOCK);
  assign prdata   = (paddr[2] == REG_IDX_SRC_CLOCK) ? CFG_DATA_W'(src_r) : '0;

  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign div_last = (cnt_r == '0);

  // shared multiplier
  always_comb begin
    unique case (state_r)
      S_MUL1: begin
        mul_a = rate_r;
        mul_b = DIV_LIMIT_P1;
      end
      S_MUL2: begin
        mul_a = rate_r;
        mul_b = pre_r;
      end
      S_MUL3: begin
        mul_a = RATE_W'(pre_r);
        mul_b = PRE_W'(div_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // one restoring divider step on the source clock
  assign rem_sh = {rem_r, src_r[cnt_r]};
  assign diff   = (PROD_W + 1)'(rem_sh) - {1'b0, prod_r};
  assign ge     = !diff[PROD_W];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if ((in_requested_rate_hz == '0) || (in_requested_rate_hz > src_r)) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_MUL1;
          end
        end
      end
      S_MUL1: state_nxt = S_DIV1;
      S_DIV1: if (div_last) state_nxt = S_PRE;
      S_PRE:  state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_DIV2;
      S_DIV2: if (div_last) state_nxt = S_DVS;
      S_DVS:  state_nxt = S_MUL3;
      S_MUL3: state_nxt = S_DIV3;
      S_DIV3: if (div_last) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    status_nxt        = status_r;
    rate_nxt          = rate_r;
    prod_nxt          = prod_r;
    rem_nxt           = rem_r;
    quo_nxt           = quo_r;
    cnt_nxt           = cnt_r;
    pre_nxt           = pre_r;
    div_nxt           = div_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_prescaler_nxt = out_prescaler_r;
    out_reload_nxt    = out_reload_r;
    out_ach_nxt       = out_ach_r;
    out_status_nxt    = out_status_r;
    unique case (state_r) inside
      S_IDLE: begin
        if (in_valid) begin
          rate_nxt = in_requested_rate_hz;
          if (in_requested_rate_hz == '0) begin
            status_nxt = STAT_ZERO;
          end else if (in_requested_rate_hz > src_r) begin
            status_nxt = STAT_ABOVE;
          end else begin
            status_nxt = STAT_OK;
          end
        end
      end
      S_MUL1, S_MUL2, S_MUL3: begin
        prod_nxt = mul_p;
        rem_nxt  = '0;
        quo_nxt  = '0;
        cnt_nxt  = CNT_W'(SRC_W - 1);
      end
      S_DIV1, S_DIV2, S_DIV3: begin
        rem_nxt = ge ? diff[SRC_W-1:0] : rem_sh[SRC_W-1:0];
        quo_nxt = {quo_r[SRC_W-2:0], ge};
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      S_PRE: begin
        if (quo_r >= SRC_W'(PRE_LIMIT - 1)) begin
          pre_nxt = PRE_W'(PRE_LIMIT);
        end else begin
          pre_nxt = PRE_W'(quo_r) + PRE_W'(1);
        end
      end
      S_DVS: begin
        if (quo_r > SRC_W'(MAX_DIVISOR)) begin
          div_nxt = DIV_W'(MAX_DIVISOR);
        end else if (quo_r == '0) begin
          div_nxt = DIV_W'(1);
        end else begin
          div_nxt = DIV_W'(quo_r);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          if (status_r == STAT_OK) begin
            out_prescaler_nxt = PRESC_W'(pre_r - PRE_W'(1));
            out_reload_nxt    = RELOAD_W'(div_r - DIV_W'(1));
            out_ach_nxt       = ACH_W'(quo_r);
          end else begin
            out_prescaler_nxt = '0;
            out_reload_nxt    = '0;
            out_ach_nxt       = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      src_r       <= SRC_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        src_r <= pwdata[SRC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r        <= status_nxt;
    rate_r          <= rate_nxt;
    prod_r          <= prod_nxt;
    rem_r           <= rem_nxt;
    quo_r           <= quo_nxt;
    cnt_r           <= cnt_nxt;
    pre_r           <= pre_nxt;
    div_r           <= div_nxt;
    out_prescaler_r <= out_prescaler_nxt;
    out_reload_r    <= out_reload_nxt;
    out_ach_r       <= out_ach_nxt;
    out_status_r    <= out_status_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_prescaler        = out_prescaler_r;
  assign out_reload_value     = out_reload_r;
  assign out_achieved_rate_hz = out_ach_r;
  assign out_status           = out_status_r;

`ifndef ASSERT_OFF
  a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != STAT_OK)) |->
      ((out_prescaler_r == '0) && (out_reload_r == '0) && (out_ach_r == '0)))
    else $error("error status with nonzero result fields");

  a_reload_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == STAT_OK)) |->
      (32'(out_reload_r) <= 32'(MAX_DIVISOR - 1)))
    else $error("reload value above divisor limit");

  a_zero_rate_short: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_requested_rate_hz == '0)) |=>
      ((state_r == S_DONE) && (status_r == STAT_ZERO)))
    else $error("zero rate did not take the short path");

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DIV1) || (state_r == S_DIV2) || (state_r == S_DIV3)) |->
      (PROD_W'(rem_r) < prod_r))
    else $error("divider remainder not below denominator");
`endif

endmodule

// ===== dv/timer_divisor_search_test.sv =====
`timescale 1ns / 100ps
// self-checking testbench for timer_divisor_search: random and corner rate requests
// over several source clock settings, checked against an in-bench divisor predictor
// depends on tds_pkg and rtl/timer_divisor_search.sv

module timer_divisor_search_test;
  import tds_pkg::*;

  localparam int MAX_DIV = MAX_DIVISOR_DEF;
  localparam logic [CFG_ADDR_W-1:0] SRC_CLOCK_ADDR = CFG_ADDR_W'(REG_IDX_SRC_CLOCK) << 2;
  localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR = CFG_ADDR_W'(4);
  localparam logic APB_READ = 1'b0;
  localparam logic APB_WRITE = 1'b1;

  typedef struct packed {
    logic [RATE_W-1:0]   rate;
    logic [PRESC_W-1:0]  prescaler;
    logic [RELOAD_W-1:0] reload_value;
    logic [ACH_W-1:0]    achieved_rate_hz;
    status_t             status;
  } timer_setting_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [RATE_W-1:0] in_requested_rate_hz = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PRESC_W-1:0] out_prescaler;
  logic [RELOAD_W-1:0] out_reload_value;
  logic [ACH_W-1:0] out_achieved_rate_hz;
  logic [STATUS_W-1:0] out_status;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  logic [RATE_W-1:0] rate_queue [$];
  timer_setting_t pending_settings [$];
  logic [SRC_W-1:0] src_clock_model = SRC_RESET;
  bit steady = 1'b0;
  int mismatch_count = 0;
  int results_checked = 0;
  int clock_settings_used = 1;
  int n_ok = 0;
  int n_zero = 0;
  int n_above = 0;

  timer_divisor_search #(
    .MAX_DIVISOR(MAX_DIV)
  ) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_requested_rate_hz(in_requested_rate_hz),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_prescaler       (out_prescaler),
    .out_reload_value    (out_reload_value),
    .out_achieved_rate_hz(out_achieved_rate_hz),
    .out_status          (out_status),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #4 clk = ~clk;

  function automatic timer_setting_t divisor_for_rate(input logic [RATE_W-1:0] rate,
                                                      input logic [SRC_W-1:0] src_hz);
    longint unsigned r, s, pre1, dv, ach;
    timer_setting_t res;
    r = rate;
    s = src_hz;
    res = '0;
    res.rate = rate;
    if (r == 0) begin
      res.status = STAT_ZERO;
    end else if (r > s) begin
      res.status = STAT_ABOVE;
    end else begin
      pre1 = s / (r * (MAX_DIV + 1)) + 1;
      if (pre1 > PRE_LIMIT) begin
        pre1 = PRE_LIMIT;
      end
      dv = s / (pre1 * r);
      if (dv > MAX_DIV) begin
        dv = MAX_DIV;
      end
      if (dv == 0) begin
        dv = 1;
      end
      ach = s / (pre1 * dv);
      res.prescaler = PRESC_W'(pre1 - 1);
      res.reload_value = RELOAD_W'(dv - 1);
      res.achieved_rate_hz = ACH_W'(ach);
      res.status = STAT_OK;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // one apb transfer; a write to the source clock register updates the predictor copy, a read is checked against it
  task automatic apb_access(input logic is_write, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (!is_write && prdata !== CFG_DATA_W'(src_clock_model)) begin
      report_mismatch($sformatf("source clock readback got %0d want %0d",
                                prdata, src_clock_model));
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (is_write && addr == SRC_CLOCK_ADDR) begin
      src_clock_model = data[SRC_W-1:0];
    end
  endtask

  // mostly legal rates around the interesting regions, the rest noise over all 30 bits
  task automatic queue_random(input int count);
    longint unsigned src_hz, rate, knee;
    int pick;
    src_hz = src_clock_model;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        rate = 0;
      end else if (pick < 14 || src_hz == 0) begin
        rate = $urandom;
      end else if (pick < 18) begin
        rate = src_hz;
      end else if (pick < 22) begin
        rate = src_hz + 1;
      end else if (pick < 45) begin
        rate = $urandom_range(1, (src_hz < 1000) ? src_hz : 1000);
      end else if (pick < 70) begin
        knee = src_hz / (MAX_DIV + 1);
        rate = knee + $urandom_range(0, 4);
        rate = (rate > 2) ? rate - 2 : 1;
        if (rate > src_hz) begin
          rate = src_hz;
        end
      end else begin
        rate = $urandom_range(1, src_hz);
      end
      rate_queue.push_back(RATE_W'(rate));
    end
  endtask

  task automatic wait_drain();
    do begin
      @(negedge clk);
    end while (rate_queue.size() != 0 || in_valid || pending_settings.size() != 0);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_settings.push_back(divisor_for_rate(in_requested_rate_hz, src_clock_model));
      end
      if (!in_valid || in_ready) begin
        if (rate_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 35)) begin
          in_valid <= 1'b1;
          in_requested_rate_hz <= rate_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    timer_setting_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_settings.size() == 0) begin
          report_mismatch("result transaction with nothing pending");
        end else begin
          want = pending_settings.pop_front();
          results_checked++;
          if (out_prescaler !== want.prescaler) begin
            report_mismatch($sformatf("rate %0d prescaler got %0d want %0d",
                                      want.rate, out_prescaler, want.prescaler));
          end
          if (out_reload_value !== want.reload_value) begin
            report_mismatch($sformatf("rate %0d reload got %0d want %0d",
                                      want.rate, out_reload_value, want.reload_value));
          end
          if (out_achieved_rate_hz !== want.achieved_rate_hz) begin
            report_mismatch($sformatf("rate %0d achieved got %0d want %0d",
                                      want.rate, out_achieved_rate_hz,
                                      want.achieved_rate_hz));
          end
          if (out_status !== want.status) begin
            report_mismatch($sformatf("rate %0d status got %0d want %s",
                                      want.rate, out_status, want.status.name()));
          end
          case (want.status)
            STAT_OK: begin
              n_ok++;
            end
            STAT_ZERO: begin
              n_zero++;
            end
            default: begin
              n_above++;
            end
          endcase
        end
      end
      out_ready <= steady || ($urandom_range(0, 99) >= 35);
    end
  end

  initial begin : stimulus
    logic [RATE_W-1:0] corner_rates [18] = '{
      30'd0, 30'd1, 30'h3FFFFFFF, 30'd100000000, 30'd100000001, 30'd99999999,
      30'd1524, 30'd1525, 30'd1526, 30'd2, 30'd1000, 30'd65536, 30'd65537,
      30'd1000000, 30'd50000000, 30'h2AAAAAAA, 30'h15555555, 30'd3
    };
    logic [CFG_DATA_W-1:0] clock_settings [7] = '{
      32'd1000000000, 32'hC0000001, 32'h3FFFFFFF, 32'd0, 32'd65537, 32'd0, 32'd0
    };
    clock_settings[5] = $urandom_range(1, 1000000000);
    clock_settings[6] = $urandom_range(1, 20000000);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    apb_access(APB_READ, SRC_CLOCK_ADDR, '0);
    @(negedge clk);
    foreach (corner_rates[i]) begin
      rate_queue.push_back(corner_rates[i]);
    end
    queue_random(300);
    wait_drain();
    foreach (clock_settings[k]) begin
      if (k == 3) begin
        // a write off the register map must leave the source clock alone
        apb_access(APB_WRITE, UNMAPPED_ADDR, 32'h00001234);
        apb_access(APB_READ, SRC_CLOCK_ADDR, '0);
      end
      apb_access(APB_WRITE, SRC_CLOCK_ADDR, clock_settings[k]);
      apb_access(APB_READ, SRC_CLOCK_ADDR, '0);
      clock_settings_used++;
      @(negedge clk);
      steady = (k == 0);
      queue_random(160);
      wait_drain();
    end
    repeat (120) @(posedge clk);
    if (pending_settings.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_settings.size()));
    end
    $display("checked %0d results over %0d source clock settings, %0d mismatches",
             results_checked, clock_settings_used, mismatch_count);
    $display("status mix: ok %0d, zero rate %0d, above source clock %0d",
             n_ok, n_zero, n_above);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("timeout waiting for the run to finish");
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tds_pkg.sv
rtl/timer_divisor_search.sv
dv/timer_divisor_search_test.sv
